@@ rtl/core/ble_enc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_enc_pkg
// Shared types, constants and bit-level functions for the BLE packet encoder.
// ----------------------------------------------------------------------------
package ble_enc_pkg;

  localparam int unsigned CrcW = 24;
  localparam logic [CrcW-1:0] CrcTaps = 24'h00065B;
  localparam logic [CrcW-1:0] CrcInitReset = 24'h555555;
  localparam logic [7:0] WhitenTaps = 8'h11;
  localparam logic [7:0] SeedMark = 8'h02;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [5:0] channel;
    logic       first_byte;
    logic       last_byte;
  } ble_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_packet;
  } ble_result_t;

  typedef struct packed {
    logic [7:0] w;
    logic [7:0] d;
  } whiten_t;

  function automatic logic [7:0] reverse8(input logic [7:0] a);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = a[i];
    end
    return r;
  endfunction

  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                              input logic [7:0] d);
    logic [CrcW-1:0] c;
    logic            fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[CrcW-1] ^ d[i];
      c  = {c[CrcW-2:0], 1'b0};
      if (fb) begin
        c = c ^ CrcTaps;
      end
    end
    return c;
  endfunction

  // lfsr held left-aligned, one bit of data per step
  function automatic whiten_t whiten_byte(input logic [7:0] w_in, input logic [7:0] d_in);
    whiten_t res;
    logic [7:0] w;
    logic [7:0] d;
    w = w_in;
    d = d_in;
    for (int i = 0; i < 8; i++) begin
      if (w[7]) begin
        w    = w ^ WhitenTaps;
        d[i] = ~d[i];
      end
      w = {w[6:0], 1'b0};
    end
    res.w = w;
    res.d = d;
    return res;
  endfunction

endpackage

@@ rtl/core/ble_enc_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_enc_in_reg
// Input register: holds one accepted item until the core takes it.
// ----------------------------------------------------------------------------
module ble_enc_in_reg
  import ble_enc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ble_item_t in_item,
  output logic      item_valid,
  output ble_item_t item,
  input  logic      item_take
);

  logic valid;

  assign in_ready   = !valid || item_take;
  assign item_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

@@ rtl/core/ble_enc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_enc_core
// CRC and whitening state, data byte encoding and CRC trailer sequencing.
// ----------------------------------------------------------------------------
module ble_enc_core
  import ble_enc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            crc_init_we,
  input  logic [CrcW-1:0] crc_init_wdata,
  input  logic            item_valid,
  input  ble_item_t       item,
  output logic            item_take,
  input  logic            res_ready,
  output logic            res_valid,
  output ble_result_t     res
);

  logic [CrcW-1:0] crc_init;
  logic [CrcW-1:0] crc_register;
  logic [CrcW-1:0] crc_register_next;
  logic [7:0]      whitening_register;
  logic [7:0]      whitening_register_next;
  logic [1:0]      trail_cnt;
  logic [1:0]      trail_cnt_next;

  logic            trailing;
  logic [CrcW-1:0] crc_start;
  logic [7:0]      w_start;
  logic [7:0]      trail_byte;
  whiten_t         wd;
  whiten_t         wt;

  assign trailing = (trail_cnt != 2'd0);

  always_comb begin
    crc_start = item.first_byte ? crc_init : crc_register;
    w_start   = item.first_byte ? (reverse8({2'b00, item.channel}) | SeedMark)
                                : whitening_register;
    wd        = whiten_byte(w_start, item.data_byte);
    case (trail_cnt)
      2'd3:    trail_byte = crc_register[23:16];
      2'd2:    trail_byte = crc_register[15:8];
      default: trail_byte = crc_register[7:0];
    endcase
    wt = whiten_byte(whitening_register, reverse8(trail_byte));
  end

  always_comb begin
    item_take               = 1'b0;
    res_valid               = 1'b0;
    res.out_byte            = reverse8(wd.d);
    res.end_of_packet       = 1'b0;
    crc_register_next       = crc_register;
    whitening_register_next = whitening_register;
    trail_cnt_next          = trail_cnt;
    if (trailing) begin
      res.out_byte      = reverse8(wt.d);
      res.end_of_packet = (trail_cnt == 2'd1);
      if (res_ready) begin
        res_valid               = 1'b1;
        whitening_register_next = wt.w;
        trail_cnt_next          = trail_cnt - 2'd1;
      end
    end else if (item_valid && res_ready) begin
      item_take               = 1'b1;
      res_valid               = 1'b1;
      crc_register_next       = crc_byte(crc_start, item.data_byte);
      whitening_register_next = wd.w;
      if (item.last_byte) begin
        trail_cnt_next = 2'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_init           <= CrcInitReset;
      crc_register       <= CrcInitReset;
      whitening_register <= 8'h00;
      trail_cnt          <= 2'd0;
    end else begin
      if (crc_init_we) begin
        crc_init <= crc_init_wdata;
      end
      crc_register       <= crc_register_next;
      whitening_register <= whitening_register_next;
      trail_cnt          <= trail_cnt_next;
    end
  end

  a_no_take_in_trailer: assert property (@(posedge clk) disable iff (rst)
    trailing |-> !item_take) else $error("item taken during crc trailer");

  a_last_starts_trailer: assert property (@(posedge clk) disable iff (rst)
    item_take && item.last_byte |=> trail_cnt == 2'd3)
    else $error("last byte did not start trailer");

  a_eop_only_final: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.end_of_packet |-> trail_cnt == 2'd1)
    else $error("end of packet outside final crc byte");

  a_crc_hold_in_trailer: assert property (@(posedge clk) disable iff (rst)
    trailing |=> $stable(crc_register)) else $error("crc changed during trailer");

endmodule

@@ rtl/core/ble_packet_crc_whiten_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_packet_crc_whiten_encoder
// BLE packet encoder: CRC-24 over the data bytes, whitening, bit reversal.
// ----------------------------------------------------------------------------
// Takes one plain packet byte per cycle unless the CRC trailer or output
// back-pressure stalls it, and returns it whitened and bit-reversed via the
// input register, then the result register. A last byte is followed by the
// three CRC bytes, high byte first, out of the CRC and whitening state
// registers one per cycle while the output is ready; the input stalls for
// them. A first byte reloads the CRC from crc_init and the whitening seed from
// the channel. Users must write crc_init only while idle; it is not enforced.
module ble_packet_crc_whiten_encoder
  import ble_enc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        crc_init_we,
  input  logic [23:0] crc_init_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // data_byte[7:0], channel[13:8], zero[15:14]
  input  logic        s_axis_tuser,  // first_byte
  input  logic        s_axis_tlast,  // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
  output logic        m_axis_tlast   // end_of_packet
);

  ble_item_t   in_item;
  ble_item_t   item;
  logic        item_valid;
  logic        item_take;
  logic        res_ready;
  logic        res_valid;
  ble_result_t res;
  logic        out_valid;
  ble_result_t out_res;

  always_comb begin
    in_item.data_byte  = s_axis_tdata[7:0];
    in_item.channel    = s_axis_tdata[13:8];
    in_item.first_byte = s_axis_tuser;
    in_item.last_byte  = s_axis_tlast;
  end

  ble_enc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  ble_enc_core u_core (
    .clk            (clk),
    .rst            (rst),
    .crc_init_we    (crc_init_we),
    .crc_init_wdata (crc_init_wdata),
    .item_valid     (item_valid),
    .item           (item),
    .item_take      (item_take),
    .res_ready      (res_ready),
    .res_valid      (res_valid),
    .res            (res)
  );

  // result register
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.out_byte;
  assign m_axis_tlast  = out_res.end_of_packet;

endmodule
